[design/nppc_pkg.sv]
// Shared types, palette constants and helper functions for the palette classifier.
package nppc_pkg;

    // Palette geometry
    localparam int unsigned NUM_CH   = 3;
    localparam int unsigned NUM_LVL  = 3;
    localparam int unsigned PAL_SIZE = 20;
    localparam int unsigned GRP_SIZE = 4;
    localparam int unsigned NUM_GRP  = PAL_SIZE / GRP_SIZE;

    // Channel order within the square array
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    typedef logic [7:0]  t_pix;
    typedef logic [15:0] t_sq;
    typedef logic [17:0] t_dist;
    typedef logic [4:0]  t_idx;

    localparam t_idx  WHITE_INDEX = 5'd18;
    localparam t_dist LIMIT_RESET = 18'd10000;

    // Every palette channel sits on one of three levels
    typedef enum logic [1:0] {
        LVL_00,
        LVL_C0,
        LVL_FF
    } t_lvl;

    // Squared channel differences, one per channel and level
    typedef t_sq [NUM_CH-1:0][NUM_LVL-1:0] t_sq_set;

    // Distances to every palette entry
    typedef t_dist [PAL_SIZE-1:0] t_dist_set;

    // Candidate for the nearest entry
    typedef struct packed {
        t_dist sq_dist;
        t_idx  idx;
    } t_cand;

    typedef t_cand [NUM_GRP-1:0] t_cand_set;

    // Channel value of a level
    function automatic t_pix lvl_value(input t_lvl lvl);
        t_pix v;
        case (lvl)
            LVL_00:  v = 8'h00;
            LVL_C0:  v = 8'hC0;
            LVL_FF:  v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Level of one channel of one palette entry
    function automatic t_lvl pal_lvl(input int unsigned idx, input int unsigned ch);
        t_lvl r;
        t_lvl g;
        t_lvl b;
        case (idx)
            0:  begin r = LVL_FF; g = LVL_C0; b = LVL_C0; end
            1:  begin r = LVL_FF; g = LVL_FF; b = LVL_C0; end
            2:  begin r = LVL_C0; g = LVL_FF; b = LVL_C0; end
            3:  begin r = LVL_C0; g = LVL_FF; b = LVL_FF; end
            4:  begin r = LVL_C0; g = LVL_C0; b = LVL_FF; end
            5:  begin r = LVL_FF; g = LVL_C0; b = LVL_FF; end
            6:  begin r = LVL_FF; g = LVL_00; b = LVL_00; end
            7:  begin r = LVL_FF; g = LVL_FF; b = LVL_00; end
            8:  begin r = LVL_00; g = LVL_FF; b = LVL_00; end
            9:  begin r = LVL_00; g = LVL_FF; b = LVL_FF; end
            10: begin r = LVL_00; g = LVL_00; b = LVL_FF; end
            11: begin r = LVL_FF; g = LVL_00; b = LVL_FF; end
            12: begin r = LVL_C0; g = LVL_00; b = LVL_00; end
            13: begin r = LVL_C0; g = LVL_C0; b = LVL_00; end
            14: begin r = LVL_00; g = LVL_C0; b = LVL_00; end
            15: begin r = LVL_00; g = LVL_C0; b = LVL_C0; end
            16: begin r = LVL_00; g = LVL_00; b = LVL_C0; end
            17: begin r = LVL_C0; g = LVL_00; b = LVL_C0; end
            18: begin r = LVL_FF; g = LVL_FF; b = LVL_FF; end
            default: begin r = LVL_00; g = LVL_00; b = LVL_00; end
        endcase
        return (ch == CH_RED) ? r : ((ch == CH_GREEN) ? g : b);
    endfunction

    // Keep the lower-index candidate a unless b is strictly closer
    function automatic t_cand pick(input t_cand a, input t_cand b);
        return (b.sq_dist < a.sq_dist) ? b : a;
    endfunction

endpackage

[design/nppc_square.sv]
// Stage one: squared differences of each pixel channel against the three palette levels.
module nppc_square (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  nppc_pkg::t_pix     i_red,
    input  nppc_pkg::t_pix     i_green,
    input  nppc_pkg::t_pix     i_blue,
    output logic               o_valid,
    input  logic               i_ready,
    output nppc_pkg::t_sq_set  o_sq
);

    logic               r_valid;
    nppc_pkg::t_sq_set  r_sq;
    nppc_pkg::t_sq_set  n_sq;
    nppc_pkg::t_pix     pix [nppc_pkg::NUM_CH];

    assign pix[nppc_pkg::CH_RED]   = i_red;
    assign pix[nppc_pkg::CH_GREEN] = i_green;
    assign pix[nppc_pkg::CH_BLUE]  = i_blue;

    // Nine small squarers, all independent
    always_comb begin
        nppc_pkg::t_pix v;
        nppc_pkg::t_pix d;
        n_sq = '0;
        for (int c = 0; c < nppc_pkg::NUM_CH; c++) begin
            for (int l = 0; l < nppc_pkg::NUM_LVL; l++) begin
                v = nppc_pkg::lvl_value(nppc_pkg::t_lvl'(l));
                d = (pix[c] >= v) ? (pix[c] - v) : (v - pix[c]);
                n_sq[c][l] = nppc_pkg::t_sq'(d) * nppc_pkg::t_sq'(d);
            end
        end
    end

    // Stage moves when empty or when downstream takes the item
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sq <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;

endmodule

[design/nppc_distance.sv]
// Stage two: squared distance to each of the twenty palette entries.
module nppc_distance (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  nppc_pkg::t_sq_set    i_sq,
    output logic                 o_valid,
    input  logic                 i_ready,
    output nppc_pkg::t_dist_set  o_dist
);

    logic                 r_valid;
    nppc_pkg::t_dist_set  r_dist;
    nppc_pkg::t_dist_set  n_dist;

    // Each entry picks its three squares by constant level and sums them
    always_comb begin
        for (int i = 0; i < nppc_pkg::PAL_SIZE; i++) begin
            n_dist[i] =
                nppc_pkg::t_dist'(i_sq[nppc_pkg::CH_RED][nppc_pkg::pal_lvl(i, nppc_pkg::CH_RED)])
              + nppc_pkg::t_dist'(i_sq[nppc_pkg::CH_GREEN][nppc_pkg::pal_lvl(i, nppc_pkg::CH_GREEN)])
              + nppc_pkg::t_dist'(i_sq[nppc_pkg::CH_BLUE][nppc_pkg::pal_lvl(i, nppc_pkg::CH_BLUE)]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dist <= n_dist;
        end
    end

    assign o_valid = r_valid;
    assign o_dist  = r_dist;

endmodule

[design/nppc_min_tree.sv]
// Stages three and four: registered minimum tree over the twenty distances.
module nppc_min_tree (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  nppc_pkg::t_dist_set  i_dist,
    output logic                 o_valid,
    input  logic                 i_ready,
    output nppc_pkg::t_cand      o_best
);

    logic                 r_valid_grp;
    logic                 r_valid_best;
    logic                 ready_grp;
    logic                 ready_best;
    nppc_pkg::t_cand_set  r_grp;
    nppc_pkg::t_cand_set  n_grp;
    nppc_pkg::t_cand      r_best;
    nppc_pkg::t_cand      n_best;

    // First level: each group of four reduced in two compare levels
    always_comb begin
        nppc_pkg::t_cand c [nppc_pkg::GRP_SIZE];
        for (int k = 0; k < nppc_pkg::NUM_GRP; k++) begin
            for (int j = 0; j < nppc_pkg::GRP_SIZE; j++) begin
                c[j].sq_dist = i_dist[k*nppc_pkg::GRP_SIZE + j];
                c[j].idx     = nppc_pkg::t_idx'(k*nppc_pkg::GRP_SIZE + j);
            end
            n_grp[k] = nppc_pkg::pick(nppc_pkg::pick(c[0], c[1]),
                                      nppc_pkg::pick(c[2], c[3]));
        end
    end

    // Second level: ordered scan over the group winners
    always_comb begin
        n_best = r_grp[0];
        for (int k = 1; k < nppc_pkg::NUM_GRP; k++) begin
            n_best = nppc_pkg::pick(n_best, r_grp[k]);
        end
    end

    assign ready_best = !r_valid_best || i_ready;
    assign ready_grp  = !r_valid_grp || ready_best;
    assign o_ready    = ready_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_grp  <= 1'b0;
            r_valid_best <= 1'b0;
        end else begin
            if (ready_grp) begin
                r_valid_grp <= i_valid;
            end
            if (ready_best) begin
                r_valid_best <= r_valid_grp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_grp && i_valid) begin
            r_grp <= n_grp;
        end
        if (ready_best && r_valid_grp) begin
            r_best <= n_best;
        end
    end

    assign o_valid = r_valid_best;
    assign o_best  = r_best;

endmodule

[design/nearest_palette_color_classifier.sv]
// Top level of the nearest palette colour classifier: stages, limit register and output.
// Classifies one RGB pixel per clock against a fixed 20-entry palette (light, normal and
// dark red/yellow/green/cyan/blue/magenta, then white and black), returning the index of
// the entry at the smallest squared distance, lowest index on a tie. If that distance is
// above far_limit (reset 10000; the user writes it through i_cfg_we / i_cfg_data only while
// idle, which the block does not enforce), index 18 is returned and o_forced_white is set.
// Squaring, distance sum, two minimum-tree levels and the limit compare are each a
// register stage; throughput is one item per clock, and a stall holds every item in place.
module nearest_palette_color_classifier (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  nppc_pkg::t_pix      i_red,
    input  nppc_pkg::t_pix      i_green,
    input  nppc_pkg::t_pix      i_blue,
    output logic                o_valid,
    input  logic                i_ready,
    output nppc_pkg::t_idx      o_color_index,
    output logic                o_forced_white,
    input  logic                i_cfg_we,
    input  nppc_pkg::t_dist     i_cfg_data
);

    logic                 sq_valid;
    logic                 sq_ready;
    nppc_pkg::t_sq_set    sq;
    logic                 dist_valid;
    logic                 dist_ready;
    nppc_pkg::t_dist_set  dist_set;
    logic                 best_valid;
    logic                 best_ready;
    nppc_pkg::t_cand      best;

    logic                 r_valid;
    nppc_pkg::t_idx       r_color_index;
    logic                 r_forced_white;
    nppc_pkg::t_dist      r_far_limit;
    logic                 too_far;

    nppc_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_sq    (sq)
    );

    nppc_distance u_distance (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .o_ready (sq_ready),
        .i_sq    (sq),
        .o_valid (dist_valid),
        .i_ready (dist_ready),
        .o_dist  (dist_set)
    );

    nppc_min_tree u_min_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_valid),
        .o_ready (dist_ready),
        .i_dist  (dist_set),
        .o_valid (best_valid),
        .i_ready (best_ready),
        .o_best  (best)
    );

    // Limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far_limit <= nppc_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_far_limit <= i_cfg_data;
        end
    end

    // Final stage: limit compare and output register
    assign too_far    = best.sq_dist > r_far_limit;
    assign best_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (best_ready) begin
            r_valid <= best_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (best_ready && best_valid) begin
            r_color_index  <= too_far ? nppc_pkg::WHITE_INDEX : best.idx;
            r_forced_white <= too_far;
        end
    end

    assign o_valid        = r_valid;
    assign o_color_index  = r_color_index;
    assign o_forced_white = r_forced_white;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the nearest palette colour classifier: stimulus, prediction, checks.
module tb;

    typedef struct packed {
        nppc_pkg::t_pix red;
        nppc_pkg::t_pix green;
        nppc_pkg::t_pix blue;
    } t_pixel;

    typedef struct packed {
        nppc_pkg::t_idx index;
        logic           forced;
    } t_verdict;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_SPARSE,
        RDY_PATTERN
    } t_rdy_mode;

    localparam int unsigned     NUM_PHASES      = 10;
    localparam int unsigned     ITEMS_PER_PHASE = 200;
    localparam int unsigned     MAX_REPORTS     = 10;
    localparam int unsigned     SETTLE_CYCLES   = 12;   // pipeline is five deep
    localparam int unsigned     LONG_HOLD       = 300;
    localparam nppc_pkg::t_dist LIMIT_MAX       = 18'h3FFFF;
    localparam nppc_pkg::t_dist DIST_MAX        = 18'd195075;

    // Palette as 24-bit RGB words, entry 0 leftmost
    localparam logic [0:19][23:0] PALETTE = {
        24'hFFC0C0, 24'hFFFFC0, 24'hC0FFC0, 24'hC0FFFF, 24'hC0C0FF, 24'hFFC0FF,
        24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'hFF00FF,
        24'hC00000, 24'hC0C000, 24'h00C000, 24'h00C0C0, 24'h0000C0, 24'hC000C0,
        24'hFFFFFF, 24'h000000
    };

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic             o_ready;
    nppc_pkg::t_pix   i_red      = '0;
    nppc_pkg::t_pix   i_green    = '0;
    nppc_pkg::t_pix   i_blue     = '0;
    logic             o_valid;
    logic             i_ready    = 1'b0;
    nppc_pkg::t_idx   o_color_index;
    logic             o_forced_white;
    logic             i_cfg_we   = 1'b0;
    nppc_pkg::t_dist  i_cfg_data = '0;

    t_pixel           pixel_q[$];
    t_verdict         verdict_q[$];
    nppc_pkg::t_dist  limit_model = nppc_pkg::LIMIT_RESET;
    t_rdy_mode        rdy_mode    = RDY_ALWAYS;
    int unsigned      hold_req    = 0;
    int unsigned      fail_count  = 0;
    int unsigned      pixels_in   = 0;
    int unsigned      results_out = 0;
    int unsigned      forced_seen = 0;

    nearest_palette_color_classifier DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_color_index  (o_color_index),
        .o_forced_white (o_forced_white),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    // Nearest entry by squared distance, lowest index on a tie, white when too far
    function automatic t_verdict classify_pixel(input t_pixel px, input nppc_pkg::t_dist limit);
        t_verdict        v;
        logic [23:0]     entry;
        int              dr;
        int              dg;
        int              db;
        int              cur_dist;
        int              best_dist;
        nppc_pkg::t_idx  best;
        best_dist = 0;
        best      = '0;
        for (int i = 0; i < 20; i++) begin
            entry    = PALETTE[i];
            dr       = int'(px.red)   - int'(entry[23:16]);
            dg       = int'(px.green) - int'(entry[15:8]);
            db       = int'(px.blue)  - int'(entry[7:0]);
            cur_dist = dr * dr + dg * dg + db * db;
            if (i == 0 || cur_dist < best_dist) begin
                best_dist = cur_dist;
                best      = nppc_pkg::t_idx'(i);
            end
        end
        if (best_dist > int'(limit)) begin
            v.index  = nppc_pkg::WHITE_INDEX;
            v.forced = 1'b1;
        end else begin
            v.index  = best;
            v.forced = 1'b0;
        end
        return v;
    endfunction

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pixel_q.size() != 0 || i_valid || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(64'd10_000_000);
        $display("FAIL");
        $finish;
    end

    // Sender: bursts of items separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    t_pixel      next_px;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_valid && o_ready) begin
                verdict_q.push_back(classify_pixel({i_red, i_green, i_blue}, limit_model));
                pixels_in++;
            end
            if (!(i_valid && !o_ready)) begin
                if (gap_left > 0) begin
                    i_valid  <= 1'b0;
                    gap_left = gap_left - 1;
                end else if (pixel_q.size() > 0) begin
                    next_px = pixel_q.pop_front();
                    i_valid <= 1'b1;
                    i_red   <= next_px.red;
                    i_green <= next_px.green;
                    i_blue  <= next_px.blue;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall mode per phase, plus an occasional long hold-off
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    logic [10:0] stall_pat = 11'b10110011101;

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            case (rdy_mode)
                RDY_ALWAYS: i_ready <= 1'b1;
                RDY_MOSTLY: i_ready <= ($urandom_range(0, 9) < 7);
                RDY_SPARSE: i_ready <= ($urandom_range(0, 9) < 3);
                default: begin
                    i_ready   <= stall_pat[0];
                    stall_pat = {stall_pat[0], stall_pat[10:1]};
                end
            endcase
        end
    end

    // Result checker
    t_verdict want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_out++;
            if (o_forced_white)
                forced_seen++;
            if (verdict_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result index=%0d forced=%0b",
                             o_color_index, o_forced_white);
            end else begin
                want = verdict_q.pop_front();
                if (o_color_index !== want.index || o_forced_white !== want.forced) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("ERROR: result %0d: index exp %0d got %0d, forced exp %0b got %0b",
                                 results_out, want.index, o_color_index,
                                 want.forced, o_forced_white);
                end
            end
        end
    end

    // Stimulus: one phase per limit setting, directed pixels first
    initial begin
        int unsigned      phase;
        int unsigned      pick;
        int               val;
        nppc_pkg::t_dist  new_limit;
        logic [23:0]      base;
        logic [23:0]      word;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            // Limit only changes once the pipeline is empty
            if (phase > 0) begin
                wait_drained();
                case (phase)
                    1:       new_limit = '0;
                    2:       new_limit = LIMIT_MAX;
                    3:       new_limit = DIST_MAX;
                    4:       new_limit = DIST_MAX + 18'd1;
                    5:       new_limit = 18'd9216;
                    6:       new_limit = 18'd9215;
                    7:       new_limit = nppc_pkg::t_dist'($urandom_range(0, DIST_MAX));
                    8:       new_limit = 18'd1;
                    default: new_limit = nppc_pkg::LIMIT_RESET;
                endcase
                @(posedge i_clk);
                i_cfg_we    <= 1'b1;
                i_cfg_data  <= new_limit;
                limit_model <= new_limit;
                @(posedge i_clk);
                i_cfg_we <= 1'b0;
            end
            rdy_mode <= t_rdy_mode'(phase % 4);
            if (phase == 2)
                hold_req <= hold_req + 1;

            // Directed pixels
            case (phase)
                0: begin
                    for (int i = 0; i < 20; i++)
                        pixel_q.push_back(t_pixel'(PALETTE[i]));
                    pixel_q.push_back(t_pixel'(24'h600000));  // tie dark red / black
                    pixel_q.push_back(t_pixel'(24'h808080));  // far from everything
                    pixel_q.push_back(t_pixel'(24'hAA55AA));
                end
                1: begin
                    pixel_q.push_back(t_pixel'(24'hE8E8E8));  // white nearest, still too far
                    pixel_q.push_back(t_pixel'(24'h010000));
                    pixel_q.push_back(t_pixel'(24'hFFC0C0));
                end
                5, 6: pixel_q.push_back(t_pixel'(24'h600000)); // distance on the limit
                default: ;
            endcase

            // Random pixels: free, near an entry, on tie levels, or at the extremes
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                base = PALETTE[$urandom_range(0, 19)];
                word = '0;
                for (int c = 0; c < 3; c++) begin
                    if (pick < 40) begin
                        word[8*c +: 8] = 8'($urandom_range(0, 255));
                    end else if (pick < 70) begin
                        val = int'(base[8*c +: 8]) + int'($urandom_range(0, 80)) - 40;
                        if (val < 0)
                            val = 0;
                        if (val > 255)
                            val = 255;
                        word[8*c +: 8] = val[7:0];
                    end else if (pick < 85) begin
                        case ($urandom_range(0, 6))
                            0:       word[8*c +: 8] = 8'h00;
                            1:       word[8*c +: 8] = 8'h60;
                            2:       word[8*c +: 8] = 8'hC0;
                            3:       word[8*c +: 8] = 8'hDF;
                            4:       word[8*c +: 8] = 8'hE0;
                            5:       word[8*c +: 8] = 8'hFF;
                            default: word[8*c +: 8] = 8'h80;
                        endcase
                    end else begin
                        case ($urandom_range(0, 2))
                            0:       word[8*c +: 8] = 8'h00;
                            1:       word[8*c +: 8] = 8'hFF;
                            default: word[8*c +: 8] = 8'($urandom_range(0, 255));
                        endcase
                    end
                end
                pixel_q.push_back(t_pixel'(word));
            end
        end

        wait_drained();
        if (verdict_q.size() != 0)
            fail_count += verdict_q.size();

        $display("Run covered %0d pixels and %0d results, %0d of them forced to white,",
                 pixels_in, results_out, forced_seen);
        $display("across %0d limit settings from zero to full scale with stalls on both sides.",
                 NUM_PHASES);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
